### src/icr_pkg.sv
// Shared widths, defaults and register indexes for the interval capacity reservation block.
package icr_pkg;
  localparam int unsigned CapW = 16;
  localparam int unsigned StnW = 11;
  localparam int unsigned CalcW = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxSegmentsDef = 1024;

  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATIONS = 2'd1;
endpackage

### src/icr_seg_mem.sv
// Segment capacity memory: one write port, one read port with registered read data.
module icr_seg_mem import icr_pkg::*; #(
  parameter int unsigned Depth = MaxSegmentsDef,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [CapW-1:0]  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [CapW-1:0]  rdata_o
);
  logic [CapW-1:0] mem_q [Depth];
  logic [CapW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### src/interval_capacity_reservation.sv
// Top level of the interval capacity reservation block: sequencer around the segment memory.
// A granted request over L segments on the line is scanned and then booked, a refused or zero-seat
//   one is only scanned, and an empty or off-line range goes straight to the result.
// Throughput: one request at a time; the next is taken from the cycle the result is presented.
// Reset, and every configuration write to the capacity or station register, start a clearing pass
//   that refills every segment; no request is taken until it ends.
module interval_capacity_reservation import icr_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CapW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [StnW-1:0]    first_station_i,
  input  logic [StnW-1:0]    end_station_i,
  input  logic [CapW-1:0]    seat_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o
);
  localparam int unsigned AddrW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CalcW-1:0] MaxSeg = CalcW'(MAX_SEGMENTS);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_DECIDE   = 3'd3;
  localparam logic [2:0] ST_BOOK     = 3'd4;
  localparam logic [2:0] ST_BOOK_END = 3'd5;
  localparam logic [2:0] ST_OUT      = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CapW-1:0]  cap_q, cap_d;
  logic [StnW-1:0]  stn_q, stn_d;
  logic [CalcW-1:0] ptr_q, ptr_d, lo_q, lo_d, hi_q, hi_d;
  logic [CapW-1:0]  seats_q, seats_d, min_q, min_d;
  logic             rvalid_q, rvalid_d, acc_q, acc_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic             out_valid_q, out_valid_d, accepted_q, accepted_d;

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [CapW-1:0]  mem_wdata, mem_rdata;

  logic [CalcW-1:0] seg_n, first_w, endm1_w, lo_w, hi_w, ptr_m1;
  logic             empty_w;

  icr_seg_mem #(.Depth(MAX_SEGMENTS), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    seg_n = '0;
    if (stn_q >= StnW'(2)) begin
      seg_n = CalcW'(stn_q) - CalcW'(1);
      if (seg_n > MaxSeg) begin
        seg_n = MaxSeg;
      end
    end
    first_w = CalcW'(first_station_i);
    endm1_w = CalcW'(end_station_i) - CalcW'(1);
    empty_w = (end_station_i == '0) || (first_w > endm1_w) || (seg_n == '0);
    lo_w    = (first_w == '0) ? CalcW'(1) : first_w;
    hi_w    = (endm1_w > seg_n) ? seg_n : endm1_w;
  end

  assign ptr_m1 = ptr_q - CalcW'(1);

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    stn_d       = stn_q;
    ptr_d       = ptr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    seats_d     = seats_q;
    acc_d       = acc_q;
    raddr_d     = raddr_q;
    rvalid_d    = 1'b0;
    out_valid_d = out_valid_q;
    accepted_d  = accepted_q;
    min_d       = min_q;
    mem_we      = 1'b0;
    mem_waddr   = raddr_q;
    mem_wdata   = mem_rdata - seats_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_m1[AddrW-1:0];

    if (rvalid_q && (mem_rdata < min_q)) begin
      min_d = mem_rdata;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q[AddrW-1:0];
        mem_wdata = cap_q;
        ptr_d     = ptr_q + CalcW'(1);
        if (ptr_q == MaxSeg - CalcW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          seats_d = seat_count_i;
          lo_d    = lo_w;
          hi_d    = hi_w;
          ptr_d   = lo_w;
          min_d   = '1;
          if (empty_w) begin
            acc_d   = 1'b0;
            state_d = ST_OUT;
          end else if (lo_w > hi_w) begin
            acc_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        ptr_d    = ptr_q + CalcW'(1);
        if (ptr_q == hi_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ptr_d = lo_q;
        if (min_d >= seats_q) begin
          acc_d   = 1'b1;
          state_d = (seats_q == '0) ? ST_OUT : ST_BOOK;
        end else begin
          acc_d   = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_BOOK: begin
        mem_re   = 1'b1;
        rvalid_d = 1'b1;
        raddr_d  = ptr_m1[AddrW-1:0];
        mem_we   = rvalid_q;
        ptr_d    = ptr_q + CalcW'(1);
        if (ptr_q == hi_q) begin
          state_d = ST_BOOK_END;
        end
      end
      ST_BOOK_END: begin
        mem_we  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          accepted_d  = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_CAPACITY) begin
        cap_d   = cfg_data_i;
        ptr_d   = '0;
        state_d = ST_CLEAR;
      end else if (cfg_index_i == CFG_STATIONS) begin
        stn_d   = cfg_data_i[StnW-1:0];
        ptr_d   = '0;
        state_d = ST_CLEAR;
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cap_q       <= '0;
      stn_q       <= StnW'(1);
      ptr_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      stn_q       <= stn_d;
      ptr_q       <= ptr_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    seats_q    <= seats_d;
    acc_q      <= acc_d;
    raddr_q    <= raddr_d;
    min_q      <= min_d;
    accepted_q <= accepted_d;
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("segment write while idle");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) || (state_q == ST_BOOK)) |-> ((ptr_q >= lo_q) && (ptr_q <= hi_q)))
    else $error("segment pointer outside request range");

  a_book_only_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BOOK_END) |-> acc_q)
    else $error("booking a refused request");
endmodule

### tb/tb_interval_capacity_reservation.sv
// Self-checking testbench for the interval capacity reservation block: directed table, random phases.
`timescale 1ns / 100ps

module tb_interval_capacity_reservation;
  import icr_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CapW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [StnW-1:0]    first_station_i;
  logic [StnW-1:0]    end_station_i;
  logic [CapW-1:0]    seat_count_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               accepted_o;

  interval_capacity_reservation uut (.*);

  typedef struct {
    bit               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [CapW-1:0]  data;
    logic [StnW-1:0]  first;
    logic [StnW-1:0]  last;
    logic [CapW-1:0]  seats;
    int               grant;
  } stim_row_t;

  logic [CapW-1:0] seats_left [1:MaxSegmentsDef];
  logic [CapW-1:0] line_capacity;
  logic [StnW-1:0] line_stations;
  bit              grant_q [$];
  int              errors = 0;
  int              stall_pct;
  int              hold_cycles = 0;
  int              hold_reqs = 0;
  int              hold_seen = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("interval_capacity_reservation regression: fail");
    $finish;
  end

  function automatic int unsigned segments_on_line();
    if (line_stations < 2) return 0;
    return (line_stations - 1 > MaxSegmentsDef) ? MaxSegmentsDef : line_stations - 1;
  endfunction

  function automatic void refill_line();
    for (int i = 1; i <= MaxSegmentsDef; i++) seats_left[i] = line_capacity;
  endfunction

  function automatic bit book_seats(logic [StnW-1:0] first, logic [StnW-1:0] last,
                                    logic [CapW-1:0] seats);
    int unsigned n, lo, hi, least;
    n = segments_on_line();
    if (last == 0 || first > last - 1 || n == 0) return 1'b0;
    lo = (first < 1) ? 1 : first;
    hi = (last - 1 > n) ? n : last - 1;
    if (lo > hi) return 1'b1;
    least = 32'hFFFF_FFFF;
    for (int i = lo; i <= hi; i++) if (seats_left[i] < least) least = seats_left[i];
    if (least < seats) return 1'b0;
    for (int i = lo; i <= hi; i++) seats_left[i] -= seats;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_cycles <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result accepted=%0b", $time, accepted_o);
        errors++;
      end else begin
        if (accepted_o !== grant_q[0]) begin
          $display("%0t: accepted mismatch expected %0b actual %0b", $time, grant_q[0],
                   accepted_o);
          errors++;
        end
        void'(grant_q.pop_front());
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CapW-1:0] data);
    bit go;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CAPACITY) line_capacity = data;
    else line_stations = data[StnW-1:0];
    refill_line();
  endtask

  task automatic send_request(logic [StnW-1:0] first, logic [StnW-1:0] last,
                              logic [CapW-1:0] seats, int grant);
    bit go;
    bit granted;
    in_valid_i      <= 1'b1;
    first_station_i <= first;
    end_station_i   <= last;
    seat_count_i    <= seats;
    do begin
      @(negedge clk_i);
      go = in_ready_o;
      @(posedge clk_i);
    end while (!go);
    granted = book_seats(first, last, seats);
    grant_q.push_back(grant < 0 ? granted : grant[0]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic random_phase(logic [CapW-1:0] cap, logic [CapW-1:0] stations, int count,
                              int idle_pct, int stall, bit pressure);
    int unsigned n;
    logic [StnW-1:0] first, last;
    logic [CapW-1:0] seats;
    drain();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_STATIONS, stations);
    stall_pct = stall;
    if (pressure) hold_reqs++;
    n = segments_on_line();
    for (int k = 0; k < count; k++) begin
      if (pressure && k == count / 2) drain();
      if ($urandom_range(99) < idle_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      if (n == 0 || $urandom_range(9) == 0) begin
        first = StnW'($urandom);
        last  = StnW'($urandom);
        seats = CapW'($urandom);
      end else begin
        first = StnW'($urandom_range(1, n));
        last  = StnW'($urandom_range(first + 1, n + 1));
        seats = CapW'($urandom_range(0, line_capacity / 4 + 1));
        if ($urandom_range(7) == 0) first = StnW'($urandom_range(0, 1));
        if ($urandom_range(7) == 0) last = StnW'($urandom_range(n + 1, 2047));
      end
      send_request(first, last, seats, -1);
    end
  endtask

  stim_row_t directed [] = '{
    '{0, CFG_CAPACITY, 0, 11'd1, 11'd2, 16'd0, 0},
    '{1, CFG_STATIONS, 16'd1, 0, 0, 0, -1},
    '{0, CFG_CAPACITY, 0, 11'd0, 11'd5, 16'd0, 0},
    '{1, CFG_CAPACITY, 16'hFFFF, 0, 0, 0, -1},
    '{1, CFG_STATIONS, 16'hF809, 0, 0, 0, -1},
    '{0, CFG_CAPACITY, 0, 11'd0, 11'd0, 16'd5, 0},
    '{0, CFG_CAPACITY, 0, 11'd5, 11'd5, 16'd1, 0},
    '{0, CFG_CAPACITY, 0, 11'd9, 11'd20, 16'hFFFF, 1},
    '{0, CFG_CAPACITY, 0, 11'd0, 11'd1, 16'hFFFF, 1},
    '{0, CFG_CAPACITY, 0, 11'd0, 11'd2047, 16'd0, 1},
    '{0, CFG_CAPACITY, 0, 11'd1, 11'd9, 16'hFFFF, 1},
    '{0, CFG_CAPACITY, 0, 11'd1, 11'd9, 16'd1, 0},
    '{1, CFG_CAPACITY, 16'd10, 0, 0, 0, -1},
    '{0, CFG_CAPACITY, 0, 11'd3, 11'd5, 16'd10, 1},
    '{0, CFG_CAPACITY, 0, 11'd4, 11'd6, 16'd1, 0},
    '{0, CFG_CAPACITY, 0, 11'd2, 11'd9, 16'd0, -1},
    '{0, CFG_CAPACITY, 0, 11'd2047, 11'd2047, 16'd0, 0},
    '{1, CFG_STATIONS, 16'd2047, 0, 0, 0, -1},
    '{0, CFG_CAPACITY, 0, 11'd1024, 11'd1025, 16'd10, 1},
    '{0, CFG_CAPACITY, 0, 11'd1025, 11'd2000, 16'd5, 1},
    '{0, CFG_CAPACITY, 0, 11'd1000, 11'd1025, 16'd10, 0},
    '{0, CFG_CAPACITY, 0, 11'd0, 11'd2047, 16'd0, 1},
    '{1, CFG_STATIONS, 16'd0, 0, 0, 0, -1},
    '{0, CFG_CAPACITY, 0, 11'd1, 11'd2, 16'd0, 0}
  };

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_CAPACITY;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    first_station_i = '0;
    end_station_i   = '0;
    seat_count_i    = '0;
    stall_pct       = 0;
    line_capacity   = '0;
    line_stations   = 11'd1;
    refill_line();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_request(directed[i].first, directed[i].last, directed[i].seats,
                     directed[i].grant);
      end
    end

    random_phase(CapW'($urandom_range(0, 50)), 16'd33, 200, 0, 0, 1'b1);
    random_phase(16'hFFFF, 16'd17, 200, 78, 0, 1'b0);
    random_phase(16'd20, 16'd65, 200, 0, 78, 1'b1);
    random_phase(CapW'($urandom), CapW'($urandom_range(2, 40)), 200, 10, 10, 1'b0);
    random_phase(CapW'($urandom), 16'd1025, 30, 0, 0, 1'b0);
    drain();
    stall_pct = 0;
    repeat (50) @(posedge clk_i);

    if (errors == 0) begin
      $display("interval_capacity_reservation regression: pass");
    end else begin
      $display("interval_capacity_reservation regression: fail");
    end
    $finish;
  end
endmodule
